FILE: sv/tcgr_pkg.sv
// Shared types and constants of the text console glyph renderer.
// Used by tcgr_ctrl, tcgr_dp and text_console_glyph_renderer; depends on nothing.
package tcgr_pkg;

    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int COLOR_W     = 32;
    localparam int CODE_W      = 8;
    localparam int GROW_W      = 4;
    localparam int PIX_PER_ROW = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic [COORD_W-1:0] CELL_W = 12'd8;
    localparam logic [DIM_W-1:0]   CELL_W_EXT = 13'd8;
    localparam logic [DIM_W-1:0]   LINE_H_EXT = 13'd16;

    // Character codes with special handling.
    localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PIXEL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CTRL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_PRESENT = 3'd4;

    localparam logic [DIM_W-1:0] FB_WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0] FB_HEIGHT_RST = 13'd768;

    // Item classes found by the decoder.
    localparam logic [2:0] CLS_GLYPH  = 3'd0;
    localparam logic [2:0] CLS_TAB    = 3'd1;
    localparam logic [2:0] CLS_LF     = 3'd2;
    localparam logic [2:0] CLS_CR     = 3'd3;
    localparam logic [2:0] CLS_BS     = 3'd4;
    localparam logic [2:0] CLS_LOAD   = 3'd5;
    localparam logic [2:0] CLS_REJECT = 3'd6;

    // Cursor operations.
    localparam logic [2:0] CUR_NONE    = 3'd0;
    localparam logic [2:0] CUR_ADVANCE = 3'd1;
    localparam logic [2:0] CUR_LF      = 3'd2;
    localparam logic [2:0] CUR_CR      = 3'd3;
    localparam logic [2:0] CUR_BS      = 3'd4;

    typedef struct packed {
        logic       accept;
        logic       row_clr;
        logic       emit_pix;
        logic       emit_stat;
        logic       last;
        logic [2:0] cur_op;
    } tcgr_cmd_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       row_last;
        logic       slot_free;
    } tcgr_sts_t;

endpackage

FILE: sv/text_console_glyph_renderer.sv
// Top level of the text console glyph renderer (8x16 bitmap font console).
// Instantiates tcgr_ctrl and tcgr_dp; depends on tcgr_pkg.
//
// Usage:
// The input channel (in_valid/in_stall) carries one word per item: either a
// character to write (kind 0) or one font row to store (kind 1). The output
// channel (out_valid/out_stall) returns result words. While the font is
// marked present, a character other than TAB, LF, CR or BS gives GLYPH_ROWS
// pixel-row words of eight 32-bit colors at the cursor, a tab gives
// TAB_SPACES space glyphs, and every other item gives one status word
// carrying the cursor after the item. The last word of each item has last
// set. The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
// is always ready and must only be written while the block is idle. One
// item is worked on at a time: accept, decode, then one glyph row per cycle
// while the receiver does not stall, from the single read port of the font
// memory. An output register parts the two channels; when the receiver
// stalls, the row sequence pauses and resumes with nothing lost. Reset
// clears the cursor and configuration to their defaults; the font memory is
// not cleared and must be loaded before use.
module text_console_glyph_renderer #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_ROWS  = 16,
    parameter int TAB_SPACES  = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcgr_pkg::COLOR_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [tcgr_pkg::CODE_W-1:0]          char_code,
    input  logic [tcgr_pkg::GROW_W-1:0]          glyph_row,
    input  logic [7:0]                           row_bits,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tcgr_pkg::STATUS_W-1:0]        status,
    output logic [tcgr_pkg::COORD_W-1:0]         pos_x,
    output logic [tcgr_pkg::COORD_W-1:0]         pos_y,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_0,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_1,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_2,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_3,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_4,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_5,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_6,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixel_7,
    output logic                                 last
);

    tcgr_pkg::tcgr_cmd_t          cmd;
    tcgr_pkg::tcgr_sts_t          sts;
    logic [tcgr_pkg::COLOR_W-1:0] pixels [tcgr_pkg::PIX_PER_ROW];

    // cfg_ready is tied high, so configuration writes are never held off.
    assign cfg_ready = 1'b1;

    tcgr_ctrl #(
        .TAB_SPACES (TAB_SPACES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcgr_dp #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .char_code (char_code),
        .glyph_row (glyph_row),
        .row_bits  (row_bits),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .status    (status),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pixels    (pixels),
        .last      (last)
    );

    // Pixel 0 is the leftmost pixel of the row.
    assign pixel_0 = pixels[0];
    assign pixel_1 = pixels[1];
    assign pixel_2 = pixels[2];
    assign pixel_3 = pixels[3];
    assign pixel_4 = pixels[4];
    assign pixel_5 = pixels[5];
    assign pixel_6 = pixels[6];
    assign pixel_7 = pixels[7];

endmodule

FILE: sv/tcgr_ctrl.sv
// Controller state machine of the glyph renderer: sequences decode, row
// emission, tab expansion and status words. Depends on tcgr_pkg.
module tcgr_ctrl #(
    parameter int TAB_SPACES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tcgr_pkg::tcgr_sts_t sts,
    output tcgr_pkg::tcgr_cmd_t cmd
);

    localparam int TW = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
    localparam logic [TW-1:0] TAB_LAST = TW'(TAB_SPACES - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_DRAW   = 2'd2;
    localparam logic [1:0] S_STAT   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [TW-1:0] tab_reg, tab_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        logic more_tabs;
        more_tabs  = (sts.cls == tcgr_pkg::CLS_TAB) && (tab_reg != TAB_LAST);
        state_next = state_reg;
        tab_next   = tab_reg;
        cmd        = '0;
        cmd.cur_op = tcgr_pkg::CUR_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                tab_next = '0;
                unique case (sts.cls)
                    tcgr_pkg::CLS_GLYPH, tcgr_pkg::CLS_TAB: state_next = S_DRAW;
                    tcgr_pkg::CLS_LF:
                    begin
                        cmd.cur_op = tcgr_pkg::CUR_LF;
                        state_next = S_STAT;
                    end
                    tcgr_pkg::CLS_CR:
                    begin
                        cmd.cur_op = tcgr_pkg::CUR_CR;
                        state_next = S_STAT;
                    end
                    tcgr_pkg::CLS_BS:
                    begin
                        cmd.cur_op = tcgr_pkg::CUR_BS;
                        state_next = S_STAT;
                    end
                    default: state_next = S_STAT;
                endcase
            end
            S_DRAW:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_pix = 1'b1;
                    if (sts.row_last)
                    begin
                        cmd.cur_op  = tcgr_pkg::CUR_ADVANCE;
                        cmd.row_clr = 1'b1;
                        if (more_tabs)
                        begin
                            tab_next = tab_reg + 1'b1;
                        end
                        else
                        begin
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_STAT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_stat = 1'b1;
                    cmd.last      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tab_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tab_reg   <= tab_next;
        end
    end

endmodule

FILE: sv/tcgr_dp.sv
// Datapath of the glyph renderer: configuration registers, cursor, font
// memory, row counter and output word register. Depends on tcgr_pkg.
module tcgr_dp #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_ROWS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcgr_pkg::COLOR_W-1:0]         cfg_data,
    input  logic                                 kind,
    input  logic [tcgr_pkg::CODE_W-1:0]          char_code,
    input  logic [tcgr_pkg::GROW_W-1:0]          glyph_row,
    input  logic [7:0]                           row_bits,
    input  logic                                 out_stall,
    input  tcgr_pkg::tcgr_cmd_t                  cmd,
    output tcgr_pkg::tcgr_sts_t                  sts,
    output logic                                 out_valid,
    output logic [tcgr_pkg::STATUS_W-1:0]        status,
    output logic [tcgr_pkg::COORD_W-1:0]         pos_x,
    output logic [tcgr_pkg::COORD_W-1:0]         pos_y,
    output logic [tcgr_pkg::COLOR_W-1:0]         pixels [tcgr_pkg::PIX_PER_ROW],
    output logic                                 last
);

    localparam int CW = $clog2(GLYPH_COUNT);
    localparam int RW = $clog2(GLYPH_ROWS);
    localparam int AW = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_ROWS - 1);

    // Configuration registers.
    logic [tcgr_pkg::DIM_W-1:0]   fb_width_reg, fb_height_reg;
    logic [tcgr_pkg::COLOR_W-1:0] fg_color_reg, bg_color_reg;
    logic                         font_present_reg;

    // Item and cursor state.
    logic [2:0]                   cls_reg, cls_next;
    logic [CW-1:0]                code_reg, code_next;
    logic                         code_ok_reg, code_ok_next;
    logic [RW-1:0]                row_reg, row_next;
    logic [tcgr_pkg::COORD_W-1:0] cur_x_reg, cur_x_next;
    logic [tcgr_pkg::COORD_W-1:0] cur_y_reg, cur_y_next;

    // Font memory.
    logic [7:0]    font_mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;

    // Output word.
    logic                         out_valid_reg, out_valid_next;
    logic [tcgr_pkg::STATUS_W-1:0] status_reg;
    logic [tcgr_pkg::COORD_W-1:0] pos_x_reg, pos_y_reg;
    logic [tcgr_pkg::COLOR_W-1:0] pix_reg [tcgr_pkg::PIX_PER_ROW];
    logic                         last_reg;

    logic                         slot_free;
    logic [7:0]                   glyph_bits;

    assign slot_free = !out_valid_reg || !out_stall;

    assign sts.cls       = cls_reg;
    assign sts.row_last  = (row_reg == ROW_LAST);
    assign sts.slot_free = slot_free;

    // Decode of an accepted item.
    always_comb
    begin
        logic [tcgr_pkg::CODE_W-1:0] gcode;
        gcode        = (char_code == tcgr_pkg::CH_TAB) ? tcgr_pkg::CH_SPACE : char_code;
        cls_next     = cls_reg;
        code_next    = code_reg;
        code_ok_next = code_ok_reg;
        if (cmd.accept)
        begin
            code_next    = gcode[CW-1:0];
            code_ok_next = ({1'b0, gcode} < 9'(GLYPH_COUNT));
            if (kind)
                cls_next = tcgr_pkg::CLS_LOAD;
            else if (!font_present_reg)
                cls_next = tcgr_pkg::CLS_REJECT;
            else if (char_code == tcgr_pkg::CH_TAB)
                cls_next = tcgr_pkg::CLS_TAB;
            else if (char_code == tcgr_pkg::CH_LF)
                cls_next = tcgr_pkg::CLS_LF;
            else if (char_code == tcgr_pkg::CH_CR)
                cls_next = tcgr_pkg::CLS_CR;
            else if (char_code == tcgr_pkg::CH_BS)
                cls_next = tcgr_pkg::CLS_BS;
            else
                cls_next = tcgr_pkg::CLS_GLYPH;
        end
    end

    // The memory is read every cycle at the row that row_reg will hold next,
    // so rdata_reg always matches row_reg while a glyph is drawn.
    always_comb
    begin
        if (cmd.accept || cmd.row_clr)
            row_next = '0;
        else if (cmd.emit_pix)
            row_next = row_reg + 1'b1;
        else
            row_next = row_reg;
        rd_addr = {code_next, row_next};
        wr_addr = {char_code[CW-1:0], glyph_row[RW-1:0]};
        wr_en   = cmd.accept && kind
                  && ({1'b0, char_code} < 9'(GLYPH_COUNT))
                  && ({1'b0, glyph_row} < 5'(GLYPH_ROWS));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            font_mem[wr_addr] <= row_bits;
        rdata_reg <= font_mem[rd_addr];
    end

    // Cursor movement.
    always_comb
    begin
        logic [tcgr_pkg::DIM_W-1:0]   nx, ny;
        logic [tcgr_pkg::COORD_W-1:0] y_down;
        nx     = {1'b0, cur_x_reg} + tcgr_pkg::CELL_W_EXT;
        ny     = {1'b0, cur_y_reg} + tcgr_pkg::LINE_H_EXT;
        y_down = (ny >= fb_height_reg || ny[tcgr_pkg::DIM_W-1]) ? '0
                 : ny[tcgr_pkg::COORD_W-1:0];
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        unique case (cmd.cur_op)
            tcgr_pkg::CUR_ADVANCE:
            begin
                if (nx >= fb_width_reg || nx[tcgr_pkg::DIM_W-1])
                begin
                    cur_x_next = '0;
                    cur_y_next = y_down;
                end
                else
                begin
                    cur_x_next = nx[tcgr_pkg::COORD_W-1:0];
                    cur_y_next = ({1'b0, cur_y_reg} >= fb_height_reg) ? '0 : cur_y_reg;
                end
            end
            tcgr_pkg::CUR_LF: cur_y_next = y_down;
            tcgr_pkg::CUR_CR: cur_x_next = '0;
            tcgr_pkg::CUR_BS:
                cur_x_next = (cur_x_reg >= tcgr_pkg::CELL_W) ? cur_x_reg - tcgr_pkg::CELL_W : '0;
            default: ;
        endcase
    end

    assign glyph_bits = code_ok_reg ? rdata_reg : 8'h00;

    always_comb
    begin
        if (cmd.emit_pix || cmd.emit_stat)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg     <= tcgr_pkg::FB_WIDTH_RST;
            fb_height_reg    <= tcgr_pkg::FB_HEIGHT_RST;
            fg_color_reg     <= '0;
            bg_color_reg     <= '0;
            font_present_reg <= 1'b0;
            cls_reg          <= tcgr_pkg::CLS_GLYPH;
            row_reg          <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tcgr_pkg::CFG_FB_WIDTH:     fb_width_reg     <= cfg_data[tcgr_pkg::DIM_W-1:0];
                    tcgr_pkg::CFG_FB_HEIGHT:    fb_height_reg    <= cfg_data[tcgr_pkg::DIM_W-1:0];
                    tcgr_pkg::CFG_FG_COLOR:     fg_color_reg     <= cfg_data;
                    tcgr_pkg::CFG_BG_COLOR:     bg_color_reg     <= cfg_data;
                    tcgr_pkg::CFG_FONT_PRESENT: font_present_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            cls_reg       <= cls_next;
            row_reg       <= row_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        code_ok_reg <= code_ok_next;
        if (cmd.emit_pix)
        begin
            status_reg <= tcgr_pkg::ST_PIXEL;
            pos_x_reg  <= cur_x_reg;
            pos_y_reg  <= cur_y_reg + {{(tcgr_pkg::COORD_W-RW){1'b0}}, row_reg};
            for (int j = 0; j < tcgr_pkg::PIX_PER_ROW; j++)
            begin
                pix_reg[j] <= glyph_bits[tcgr_pkg::PIX_PER_ROW-1-j] ? fg_color_reg
                                                                     : bg_color_reg;
            end
            last_reg <= cmd.last;
        end
        else if (cmd.emit_stat)
        begin
            if (cls_reg == tcgr_pkg::CLS_LOAD)
                status_reg <= tcgr_pkg::ST_LOADED;
            else if (cls_reg == tcgr_pkg::CLS_REJECT)
                status_reg <= tcgr_pkg::ST_REJECT;
            else
                status_reg <= tcgr_pkg::ST_CTRL;
            pos_x_reg <= cur_x_reg;
            pos_y_reg <= cur_y_reg;
            for (int j = 0; j < tcgr_pkg::PIX_PER_ROW; j++)
            begin
                pix_reg[j] <= '0;
            end
            last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pixels    = pix_reg;
    assign last      = last_reg;

endmodule
